// ===== sv/lab_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the leased arena bump allocator
// no dependencies; imported by every other module of the block
package lab_pkg;

  localparam int LAB_MAX_LEASES = 16;

  localparam int OP_W    = 2;
  localparam int HELD_W  = 8;
  localparam int HANDLE_W = 48;
  localparam int BYTES_W = 32;
  localparam int DEPTH_W = 5;
  localparam int ADDR_W  = 50;
  localparam int BASE_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int SHIFT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_ACQUIRE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic exec;
    logic pop_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop;
  } dp_status_t;

endpackage

// ===== sv/lab_ctrl.sv =====
`timescale 1ns / 1ps
// controller: input/output handshake and the release pop sequence
// depends on lab_pkg
module lab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lab_pkg::dp_status_t status,
  output lab_pkg::ctrl_cmd_t  cmd
);
  import lab_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    accept       = 1'b0;
    cmd.exec     = 1'b0;
    cmd.pop_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        accept   = in_valid && !in_stall;
        cmd.exec = accept;
        if (accept && status.pop) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_pop_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> in_stall)
    else $error("input taken during stack pop");

  a_release_enters_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status.pop |=> state_r == ST_POP)
    else $error("successful release did not restore cursor");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

// ===== sv/lab_datapath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, cursor, lease count, snapshot stack and result register
// depends on lab_pkg
module lab_datapath #(
  parameter int MAX_LEASES = lab_pkg::LAB_MAX_LEASES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [lab_pkg::OP_W-1:0]          in_operation,
  input  logic [lab_pkg::HELD_W-1:0]        in_held_depth,
  input  logic [lab_pkg::HANDLE_W-1:0]      in_arena_handle,
  input  logic [lab_pkg::BYTES_W-1:0]       in_request_bytes,
  input  lab_pkg::ctrl_cmd_t                cmd,
  output lab_pkg::dp_status_t               status,
  output logic                              out_success,
  output logic [lab_pkg::DEPTH_W-1:0]       out_granted_depth,
  output logic [lab_pkg::ADDR_W-1:0]        out_block_address
);
  import lab_pkg::*;

  localparam int CW = $clog2(MAX_LEASES + 1);
  localparam int AW = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;

  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [BASE_W:0]    end_r;
  logic [ADDR_W-1:0]  cursor_r;
  logic [CW-1:0]      count_r;
  logic [ADDR_W-1:0]  stack_mem [MAX_LEASES];
  logic [ADDR_W-1:0]  rd_data_r;

  logic               cfg_hit;
  logic [ADDR_W-1:0]  cfg_m1;
  logic [ADDR_W-1:0]  cursor_init;
  logic [CW-1:0]      count_m1;
  logic [ADDR_W-1:0]  end_ext;
  logic [ADDR_W-1:0]  room;
  logic [BYTES_W-1:0] align_m1;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] rounded;
  logic               held_hit;
  logic               acq_ok;
  logic               rel_ok;
  logic               alc_ok;

  // config next values and re-initialized cursor
  always_comb begin
    base_nxt  = base_r;
    size_nxt  = size_r;
    shift_nxt = shift_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: begin
          base_nxt = cfg_wdata[BASE_W-1:0];
          cfg_hit  = 1'b1;
        end
        CFG_SIZE: begin
          size_nxt = cfg_wdata[SIZE_W-1:0];
          cfg_hit  = 1'b1;
        end
        CFG_ALIGN: begin
          shift_nxt = cfg_wdata[SHIFT_W-1:0];
          cfg_hit   = 1'b1;
        end
        default:   ;
      endcase
    end
    cfg_m1      = (ADDR_W'(1) << shift_nxt) - ADDR_W'(1);
    cursor_init = (ADDR_W'(base_nxt) + cfg_m1) & ~cfg_m1;
  end

  // operation checks
  always_comb begin
    count_m1  = count_r - CW'(1);
    end_ext   = ADDR_W'(end_r);
    room      = end_ext - cursor_r;
    align_m1  = (BYTES_W'(1) << shift_r) - BYTES_W'(1);
    bytes_sum = {1'b0, in_request_bytes} + {1'b0, align_m1};
    rounded   = bytes_sum[BYTES_W-1:0] & ~align_m1;
    held_hit  = (in_held_depth != '0) && (in_held_depth == HELD_W'(count_r));
    acq_ok    = (in_operation == OP_ACQUIRE) && (in_held_depth == '0) &&
                (in_arena_handle != '0) && (count_r != CW'(MAX_LEASES));
    rel_ok    = (in_operation == OP_RELEASE) && held_hit;
    alc_ok    = (in_operation == OP_ALLOCATE) && held_hit &&
                (cursor_r <= end_ext) && (ADDR_W'(in_request_bytes) <= room);
  end

  assign status.pop = rel_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      size_r   <= '0;
      shift_r  <= '0;
      end_r    <= '0;
      cursor_r <= '0;
      count_r  <= '0;
    end else if (cfg_hit) begin
      base_r   <= base_nxt;
      size_r   <= size_nxt;
      shift_r  <= shift_nxt;
      end_r    <= (BASE_W + 1)'(base_nxt) + (BASE_W + 1)'(size_nxt);
      cursor_r <= cursor_init;
      count_r  <= '0;
    end else if (cmd.pop_load) begin
      cursor_r <= rd_data_r;
    end else if (cmd.exec) begin
      if (acq_ok) begin
        count_r <= count_r + CW'(1);
      end else if (rel_ok) begin
        count_r <= count_m1;
      end else if (alc_ok) begin
        cursor_r <= cursor_r + ADDR_W'(rounded);
      end
    end
  end

  // snapshot stack
  always_ff @(posedge clk) begin
    if (cmd.exec && acq_ok) begin
      stack_mem[count_r[AW-1:0]] <= cursor_r;
    end
    rd_data_r <= stack_mem[count_m1[AW-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_success       <= acq_ok || rel_ok || alc_ok;
      out_granted_depth <= acq_ok ? DEPTH_W'(count_r + CW'(1)) : '0;
      out_block_address <= alc_ok ? cursor_r : '0;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEASES))
    else $error("lease count beyond stack depth");

endmodule

// ===== sv/leased_arena_bump_allocator_unit.sv =====
`timescale 1ns / 1ps
// Leased arena bump allocator, top level. Depends on lab_pkg, lab_ctrl, lab_datapath.
//
// Input channel (in_valid/in_stall) carries one item: operation, held_depth,
// arena_handle, request_bytes. Result channel (out_valid/out_stall) returns one
// item per input item: success, granted_depth, block_address, in order.
// Config port: cfg_we with cfg_index 0 base, 1 size, 2 align shift; any write
// to these resets the cursor to the aligned base and clears the lease count.
// Write only while no item is in flight.
// The result is registered and valid in the cycle after the item is accepted.
// Acquire, allocate, a failed release and unused codes leave the input free for
// the next item; a successful release then holds in_stall high in ST_POP, since the
// saved cursor comes back through the registered read port of the snapshot stack.
// The result register is free to take the next item as soon as its current
// item is taken; while out_stall holds a waiting result, in_stall is high.
// Reset (synchronous, rst_n low) clears all config registers, the cursor,
// the lease count and out_valid; stack contents are not cleared.
module leased_arena_bump_allocator_unit #(
  parameter int MAX_LEASES = lab_pkg::LAB_MAX_LEASES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lab_pkg::OP_W-1:0]          in_operation,
  input  logic [lab_pkg::HELD_W-1:0]        in_held_depth,
  input  logic [lab_pkg::HANDLE_W-1:0]      in_arena_handle,
  input  logic [lab_pkg::BYTES_W-1:0]       in_request_bytes,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_success,
  output logic [lab_pkg::DEPTH_W-1:0]       out_granted_depth,
  output logic [lab_pkg::ADDR_W-1:0]        out_block_address
);
  import lab_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lab_datapath #(
    .MAX_LEASES (MAX_LEASES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_held_depth     (in_held_depth),
    .in_arena_handle   (in_arena_handle),
    .in_request_bytes  (in_request_bytes),
    .cmd               (cmd),
    .status            (status),
    .out_success       (out_success),
    .out_granted_depth (out_granted_depth),
    .out_block_address (out_block_address)
  );

endmodule
